FILE: rtl/quaternion_to_rotation_matrix_macros.svh
// Assertion macros shared by the quaternion-to-matrix checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define Q2R_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Consequent that must hold after the antecedent, at the delay given by n.
`define Q2R_ASSERT_LAT(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##n (cons)) else $error(msg);

`endif

FILE: rtl/q2r_pkg.sv
// Types and constants for the quaternion-to-rotation-matrix datapath.
// No dependencies; used by the round stage, the top level and the checker.
package q2r_pkg;

  localparam int QUAT_W  = 16;
  localparam int PROD_W  = 2 * QUAT_W;
  localparam int MAT_W   = 18;
  localparam int LATENCY = 3;

  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [MAT_W-1:0]  mat_t;

  localparam mat_t MAT_MAX = 18'sh1FFFF;
  localparam mat_t MAT_MIN = 18'sh20000;

  // Nine of the distinct component products of one quaternion (all but ww).
  typedef struct packed {
    prod_t xx;
    prod_t yy;
    prod_t zz;
    prod_t xy;
    prod_t xz;
    prod_t yz;
    prod_t xw;
    prod_t yw;
    prod_t zw;
  } prod_set_t;

  function automatic prod_t qmul(quat_t a, quat_t b);
    prod_t ea;
    prod_t eb;
    ea = {{(PROD_W-QUAT_W){a[QUAT_W-1]}}, a};
    eb = {{(PROD_W-QUAT_W){b[QUAT_W-1]}}, b};
    return ea * eb;
  endfunction

endpackage

FILE: rtl/quaternion_to_rotation_matrix.sv
// Top level: quaternion (Q1.14) to 3x3 rotation matrix (Q3.14), column-major.
// Depends on q2r_pkg and q2r_round.
//
// Takes one quaternion per clock and delivers its nine matrix entries, with
// done_o high for one cycle, once they pass the three register stages
// (products, sums, round/saturate). busy is never raised, so a new beat may
// follow every cycle. The receiver cannot stall; results must be taken in
// the cycle done_o is high. No normalization is done: a non-unit quaternion
// gives a scaled matrix, and entries beyond the Q3.14 range clip.
module quaternion_to_rotation_matrix import q2r_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  quat_t quat_x_i,
  input  quat_t quat_y_i,
  input  quat_t quat_z_i,
  input  quat_t quat_w_i,
  output logic  done_o,
  output mat_t  m00_o,
  output mat_t  m10_o,
  output mat_t  m20_o,
  output mat_t  m01_o,
  output mat_t  m11_o,
  output mat_t  m21_o,
  output mat_t  m02_o,
  output mat_t  m12_o,
  output mat_t  m22_o
);

  localparam int SUM_W = ((2 * FRAC_BITS > PROD_W) ? 2 * FRAC_BITS : PROD_W) + 3;
  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << (2 * FRAC_BITS);

  typedef logic signed [SUM_W-1:0] sum_t;

  // Sign-extend a product and double it.
  function automatic sum_t dbl(prod_t p);
    return {{(SUM_W-PROD_W-1){p[PROD_W-1]}}, p, 1'b0};
  endfunction

  logic               accept;
  logic [LATENCY-1:0] vld_q;
  logic [LATENCY-1:0] vld_d;
  prod_set_t          prod_d;
  prod_set_t          prod_q;
  sum_t               sum_d [9];
  sum_t               sum_q [9];
  mat_t               mat   [9];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    prod_d.xx = qmul(quat_x_i, quat_x_i);
    prod_d.yy = qmul(quat_y_i, quat_y_i);
    prod_d.zz = qmul(quat_z_i, quat_z_i);
    prod_d.xy = qmul(quat_x_i, quat_y_i);
    prod_d.xz = qmul(quat_x_i, quat_z_i);
    prod_d.yz = qmul(quat_y_i, quat_z_i);
    prod_d.xw = qmul(quat_x_i, quat_w_i);
    prod_d.yw = qmul(quat_y_i, quat_w_i);
    prod_d.zw = qmul(quat_z_i, quat_w_i);
  end

  always_comb begin
    sum_d[0] = ONE - dbl(prod_q.yy) - dbl(prod_q.zz);
    sum_d[1] = dbl(prod_q.xy) + dbl(prod_q.zw);
    sum_d[2] = dbl(prod_q.xz) - dbl(prod_q.yw);
    sum_d[3] = dbl(prod_q.xy) - dbl(prod_q.zw);
    sum_d[4] = ONE - dbl(prod_q.xx) - dbl(prod_q.zz);
    sum_d[5] = dbl(prod_q.yz) + dbl(prod_q.xw);
    sum_d[6] = dbl(prod_q.xz) + dbl(prod_q.yw);
    sum_d[7] = dbl(prod_q.yz) - dbl(prod_q.xw);
    sum_d[8] = ONE - dbl(prod_q.xx) - dbl(prod_q.yy);
  end

  // Advance the valid bits one stage per cycle.
  assign vld_d = {vld_q[LATENCY-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
    end
    if (vld_q[0]) begin
      sum_q <= sum_d;
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_round
    q2r_round #(
      .FRAC_BITS (FRAC_BITS),
      .SUM_W     (SUM_W)
    ) u_round (
      .clk_i (clk_i),
      .en_i  (vld_q[1]),
      .sum_i (sum_q[i]),
      .mat_o (mat[i])
    );
  end

  assign done_o = vld_q[LATENCY-1];
  assign m00_o  = mat[0];
  assign m10_o  = mat[1];
  assign m20_o  = mat[2];
  assign m01_o  = mat[3];
  assign m11_o  = mat[4];
  assign m21_o  = mat[5];
  assign m02_o  = mat[6];
  assign m12_o  = mat[7];
  assign m22_o  = mat[8];

endmodule

FILE: rtl/q2r_round.sv
// Registered round-half-up and saturate from 2*FRAC_BITS to FRAC_BITS fraction bits.
// Depends on q2r_pkg for the result type and its bounds.
module q2r_round import q2r_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int SUM_W     = 35
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output mat_t                    mat_o
);

  localparam int SH_W = SUM_W - FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SH_W-1:0] SAT_HI = {{(SH_W-MAT_W){MAT_MAX[MAT_W-1]}}, MAT_MAX};
  localparam logic signed [SH_W-1:0] SAT_LO = {{(SH_W-MAT_W){MAT_MIN[MAT_W-1]}}, MAT_MIN};

  logic signed [SUM_W-1:0] rnd;
  logic signed [SH_W-1:0]  sh;
  mat_t                    mat_d;
  mat_t                    mat_q;

  always_comb begin
    rnd = sum_i + HALF;
    // floor after the half-LSB bias gives round half up
    sh  = rnd[SUM_W-1:FRAC_BITS];
    if (sh > SAT_HI) begin
      mat_d = MAT_MAX;
    end else if (sh < SAT_LO) begin
      mat_d = MAT_MIN;
    end else begin
      mat_d = sh[MAT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

FILE: rtl/q2r_checker.sv
// Port-level checker for quaternion_to_rotation_matrix, bound to the top level.
// Depends on q2r_pkg and quaternion_to_rotation_matrix_macros.svh.
`include "quaternion_to_rotation_matrix_macros.svh"

module q2r_checker import q2r_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  start,
  input logic  busy,
  input quat_t quat_x_i,
  input quat_t quat_y_i,
  input quat_t quat_z_i,
  input quat_t quat_w_i,
  input logic  done_o,
  input mat_t  m00_o,
  input mat_t  m10_o,
  input mat_t  m20_o,
  input mat_t  m01_o,
  input mat_t  m11_o,
  input mat_t  m21_o,
  input mat_t  m02_o,
  input mat_t  m12_o,
  input mat_t  m22_o
);

  localparam mat_t DIAG = (FRAC_BITS >= MAT_W - 1) ? MAT_MAX : MAT_W'(1 << FRAC_BITS);

  logic beat_in;
  logic zero_quat;
  logic no_zw;
  logic ident_ok;

  assign beat_in   = start && !busy;
  assign zero_quat = (quat_x_i == '0) && (quat_y_i == '0) && (quat_z_i == '0) &&
                     (quat_w_i == '0);
  assign no_zw     = (quat_z_i == '0) || (quat_w_i == '0);

  // zero quaternion: identity scaled to the diagonal, every other entry zero
  assign ident_ok  = (m00_o == DIAG) && (m11_o == DIAG) && (m22_o == DIAG) &&
                     (m10_o == '0) && (m20_o == '0) && (m01_o == '0) &&
                     (m21_o == '0) && (m02_o == '0) && (m12_o == '0);

  `Q2R_ASSERT_LAT(a_beat_done, beat_in, 3, done_o, "accepted beat produced no result")

  `Q2R_ASSERT_ALWAYS(a_done_src, !done_o || $past(beat_in, LATENCY), "result without a beat")

  `Q2R_ASSERT_LAT(a_zero_ident, beat_in && zero_quat, 3, ident_ok, "zero quaternion bad matrix")

  `Q2R_ASSERT_LAT(a_xy_sym, beat_in && no_zw, 3, m10_o == m01_o, "m10 differs from m01")

endmodule

bind quaternion_to_rotation_matrix q2r_checker #(.FRAC_BITS(FRAC_BITS)) u_q2r_checker (.*);
